@@ hdl/cba_pkg.sv @@
// Shared types and constants for the chained block allocator.
// Holds command, status and link codes and the controller/datapath interface structs.
// Depends on nothing.
package cba_pkg;

   localparam int WORD_ADDR_W = 16;
   localparam int COMMAND_W   = 3;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 9;
   localparam int KIND_W      = 2;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_ALLOCATE = 3'd0,
      CMD_FREE     = 3'd1,
      CMD_READ     = 3'd2,
      CMD_WRITE    = 3'd3,
      CMD_LENGTH   = 3'd4
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_BROKEN  = 2'd2,
      ST_OUTSIDE = 2'd3
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      LINK_FREE = 2'd0,
      LINK_END  = 2'd1,
      LINK_NEXT = 2'd2
   } link_kind_type;

   typedef enum logic [2:0] {
      RD_HOLD,
      RD_BLOCK,
      RD_FIRST,
      RD_NEXT,
      RD_LINK
   } rd_sel_type;

   typedef enum logic {
      WA_CURRENT,
      WA_BLOCK
   } wr_addr_sel_type;

   typedef enum logic {
      FOUND_SCAN,
      FOUND_LINK
   } found_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_INCR,
      RES_START
   } res_sel_type;

   typedef struct packed {
      logic            capture;
      rd_sel_type      rd_sel;
      logic            wr_en;
      wr_addr_sel_type wr_addr_sel;
      link_kind_type   wr_kind;
      logic            found_en;
      found_sel_type   found_sel;
      logic            count_inc;
      logic            rsp_load;
      res_sel_type     res_sel;
      status_type      status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic                 in_store;
      logic                 last_word;
      logic                 scan_last;
      logic                 walk_full;
      link_kind_type        kind;
      logic                 out_free;
   } dp_status_type;

endpackage

@@ hdl/cba_ctrl.sv @@
// Controller state machine of the chained block allocator.
// Sequences decode, link table search, chain walk and response; drives the datapath.
// Depends on cba_pkg.
module cba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cba_pkg::dp_status_type status,
   output cba_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DEC0,
      S_DEC1,
      S_DEC2,
      S_DISPATCH,
      S_SEARCH,
      S_LINK,
      S_WALK,
      S_APPEND,
      S_FINISH
   } state_type;

   state_type             state_ff, state_in;
   cba_pkg::status_type   status_ff, status_in;
   cba_pkg::res_sel_type  res_sel_ff, res_sel_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      res_sel_in = res_sel_ff;
      cmd         = '0;
      cmd.rd_sel  = cba_pkg::RD_HOLD;
      cmd.status  = status_ff;
      cmd.res_sel = res_sel_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = cba_pkg::WA_CURRENT;
            cmd.wr_kind     = cba_pkg::LINK_FREE;
            cmd.rd_sel      = cba_pkg::RD_NEXT;
            if (status.scan_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DEC0;
            end
         end
         S_DEC0: begin
            state_in = S_DEC1;
         end
         S_DEC1: begin
            state_in = S_DEC2;
         end
         S_DEC2: begin
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            status_in  = cba_pkg::ST_OK;
            res_sel_in = cba_pkg::RES_ZERO;
            case (status.command)
               cba_pkg::CMD_ALLOCATE: begin
                  cmd.rd_sel = cba_pkg::RD_FIRST;
                  state_in   = S_SEARCH;
               end
               cba_pkg::CMD_FREE, cba_pkg::CMD_LENGTH: begin
                  if (!status.in_store) begin
                     status_in = cba_pkg::ST_OUTSIDE;
                     state_in  = S_FINISH;
                  end else begin
                     cmd.rd_sel = cba_pkg::RD_BLOCK;
                     state_in   = S_WALK;
                  end
               end
               cba_pkg::CMD_READ, cba_pkg::CMD_WRITE: begin
                  if (!status.in_store) begin
                     status_in = cba_pkg::ST_OUTSIDE;
                     state_in  = S_FINISH;
                  end else if (!status.last_word) begin
                     res_sel_in = cba_pkg::RES_INCR;
                     state_in   = S_FINISH;
                  end else begin
                     cmd.rd_sel = cba_pkg::RD_BLOCK;
                     state_in   = S_LINK;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SEARCH: begin
            if (status.kind == cba_pkg::LINK_FREE) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_addr_sel = cba_pkg::WA_CURRENT;
               cmd.wr_kind     = cba_pkg::LINK_END;
               cmd.found_en    = 1'b1;
               cmd.found_sel   = cba_pkg::FOUND_SCAN;
               status_in       = cba_pkg::ST_OK;
               res_sel_in      = cba_pkg::RES_START;
               if (status.command == cba_pkg::CMD_WRITE) begin
                  state_in = S_APPEND;
               end else begin
                  state_in = S_FINISH;
               end
            end else if (status.scan_last) begin
               status_in  = cba_pkg::ST_NO_FREE;
               res_sel_in = cba_pkg::RES_ZERO;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_sel = cba_pkg::RD_NEXT;
            end
         end
         S_APPEND: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = cba_pkg::WA_BLOCK;
            cmd.wr_kind     = cba_pkg::LINK_NEXT;
            state_in        = S_FINISH;
         end
         S_LINK: begin
            case (status.kind)
               cba_pkg::LINK_END: begin
                  if (status.command == cba_pkg::CMD_WRITE) begin
                     cmd.rd_sel = cba_pkg::RD_FIRST;
                     state_in   = S_SEARCH;
                  end else begin
                     status_in = cba_pkg::ST_BROKEN;
                     state_in  = S_FINISH;
                  end
               end
               cba_pkg::LINK_NEXT: begin
                  cmd.found_en  = 1'b1;
                  cmd.found_sel = cba_pkg::FOUND_LINK;
                  res_sel_in    = cba_pkg::RES_START;
                  state_in      = S_FINISH;
               end
               default: begin
                  status_in = cba_pkg::ST_BROKEN;
                  state_in  = S_FINISH;
               end
            endcase
         end
         S_WALK: begin
            case (status.kind)
               cba_pkg::LINK_END, cba_pkg::LINK_NEXT: begin
                  cmd.count_inc = 1'b1;
                  if (status.command == cba_pkg::CMD_FREE) begin
                     cmd.wr_en       = 1'b1;
                     cmd.wr_addr_sel = cba_pkg::WA_CURRENT;
                     cmd.wr_kind     = cba_pkg::LINK_FREE;
                  end
                  if (status.kind == cba_pkg::LINK_END) begin
                     state_in = S_FINISH;
                  end else if (status.walk_full) begin
                     status_in = cba_pkg::ST_BROKEN;
                     state_in  = S_FINISH;
                  end else begin
                     cmd.rd_sel = cba_pkg::RD_LINK;
                  end
               end
               default: begin
                  status_in = cba_pkg::ST_BROKEN;
                  state_in  = S_FINISH;
               end
            endcase
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         status_ff  <= cba_pkg::ST_OK;
         res_sel_ff <= cba_pkg::RES_ZERO;
      end else begin
         state_ff   <= state_in;
         status_ff  <= status_in;
         res_sel_ff <= res_sel_in;
      end
   end

endmodule

@@ hdl/cba_datapath.sv @@
// Datapath of the chained block allocator: request registers, address decode,
// link table memory with write forwarding, walk counter and response register.
// Depends on cba_pkg.
module cba_datapath #(
   parameter int NUM_BLOCKS  = 256,
   parameter int BLOCK_WORDS = 128,
   parameter int BASE_WORDS  = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cba_pkg::COMMAND_W-1:0]       req_command,
   input  logic [cba_pkg::WORD_ADDR_W-1:0]     req_word_address,
   input  cba_pkg::ctrl_cmd_type               cmd,
   output cba_pkg::dp_status_type              status,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [cba_pkg::WORD_ADDR_W-1:0]     rsp_result_address,
   output logic [cba_pkg::STATUS_W-1:0]        rsp_status,
   output logic [cba_pkg::COUNT_W-1:0]         rsp_block_count
);

   localparam int AW        = cba_pkg::WORD_ADDR_W;
   localparam int IDX_W     = $clog2(NUM_BLOCKS);
   localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
   localparam int ENTRY_W   = cba_pkg::KIND_W + IDX_W;
   localparam int STORE_END = BASE_WORDS + NUM_BLOCKS * BLOCK_WORDS;
   // Block number by reciprocal multiplication; exact for every 16-bit offset.
   localparam int DIV_SHIFT = AW + $clog2(BLOCK_WORDS);
   localparam int RECIP     = (2 ** DIV_SHIFT + BLOCK_WORDS - 1) / BLOCK_WORDS;
   localparam int RECIP_W   = AW + 2;
   localparam int PROD_W    = AW + RECIP_W;

   logic [cba_pkg::COMMAND_W-1:0] cmd_ff;
   logic [AW-1:0]                 addr_ff;
   logic [AW-1:0]                 rel_ff, rel_in;
   logic                          in_store_ff, in_store_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [IDX_W-1:0]              blk_ff, blk_in;
   logic [AW-1:0]                 base_ff, base_in;
   logic [IDX_W-1:0]              rd_addr_ff, rd_addr_in;
   logic [ENTRY_W-1:0]            rd_data_ff;
   logic                          wr_en_ff;
   logic [IDX_W-1:0]              wr_addr_ff, wr_addr_in;
   logic [ENTRY_W-1:0]            wr_data_ff, wr_data_in;
   logic [IDX_W-1:0]              found_ff;
   logic [CNT_W-1:0]              count_ff;
   logic                          rsp_valid_ff;
   logic [AW-1:0]                 rsp_address_ff, rsp_address_in;
   cba_pkg::status_type           rsp_status_ff;
   logic [cba_pkg::COUNT_W-1:0]   rsp_count_ff;

   logic [31:0]        addr_ext;
   logic [ENTRY_W-1:0] cur_entry;
   logic [IDX_W-1:0]   link_idx;
   logic [AW-1:0]      start_addr;

   logic [ENTRY_W-1:0] link_mem [NUM_BLOCKS];

   assign addr_ext    = 32'(req_word_address);
   assign in_store_in = (addr_ext >= 32'(BASE_WORDS)) && (addr_ext < 32'(STORE_END));
   assign rel_in      = req_word_address - AW'(BASE_WORDS);
   assign prod_in     = PROD_W'(rel_ff) * PROD_W'(RECIP);
   assign blk_in      = IDX_W'(prod_ff >> DIV_SHIFT);
   assign base_in     = AW'(32'(blk_ff) * 32'(BLOCK_WORDS));

   // A write at the last edge is not yet visible in the registered read data.
   assign cur_entry = (wr_en_ff && (wr_addr_ff == rd_addr_ff)) ? wr_data_ff : rd_data_ff;
   assign link_idx  = cur_entry[IDX_W-1:0];

   always_comb begin
      case (cmd.rd_sel)
         cba_pkg::RD_BLOCK: rd_addr_in = blk_ff;
         cba_pkg::RD_FIRST: rd_addr_in = '0;
         cba_pkg::RD_NEXT:  rd_addr_in = rd_addr_ff + IDX_W'(1);
         cba_pkg::RD_LINK:  rd_addr_in = link_idx;
         default:           rd_addr_in = rd_addr_ff;
      endcase
   end

   assign wr_addr_in = (cmd.wr_addr_sel == cba_pkg::WA_BLOCK) ? blk_ff : rd_addr_ff;
   assign wr_data_in = {cmd.wr_kind, found_ff};

   assign start_addr = AW'(32'(BASE_WORDS) + 32'(found_ff) * 32'(BLOCK_WORDS));

   always_comb begin
      case (cmd.res_sel)
         cba_pkg::RES_INCR:  rsp_address_in = addr_ff + AW'(1);
         cba_pkg::RES_START: rsp_address_in = start_addr;
         default:            rsp_address_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en_ff) begin
         link_mem[wr_addr_ff] <= wr_data_ff;
      end
      rd_data_ff <= link_mem[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_addr_ff   <= '0;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_addr_ff <= rd_addr_in;
         wr_en_ff   <= cmd.wr_en;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      blk_ff     <= blk_in;
      base_ff    <= base_in;
      wr_addr_ff <= wr_addr_in;
      wr_data_ff <= wr_data_in;
      if (cmd.capture) begin
         cmd_ff      <= req_command;
         addr_ff     <= req_word_address;
         rel_ff      <= rel_in;
         in_store_ff <= in_store_in;
         count_ff    <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + CNT_W'(1);
      end
      if (cmd.found_en) begin
         found_ff <= (cmd.found_sel == cba_pkg::FOUND_LINK) ? link_idx : rd_addr_ff;
      end
      if (cmd.rsp_load) begin
         rsp_address_ff <= rsp_address_in;
         rsp_status_ff  <= cmd.status;
         rsp_count_ff   <= cba_pkg::COUNT_W'(count_ff);
      end
   end

   assign status.command   = cmd_ff;
   assign status.in_store  = in_store_ff;
   assign status.last_word = ((rel_ff - base_ff) == AW'(BLOCK_WORDS - 1));
   assign status.scan_last = (rd_addr_ff == IDX_W'(NUM_BLOCKS - 1));
   assign status.walk_full = (count_ff == CNT_W'(NUM_BLOCKS - 1));
   assign status.kind      = cba_pkg::link_kind_type'(cur_entry[ENTRY_W-1 -: cba_pkg::KIND_W]);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_address_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_block_count    = rsp_count_ff;

endmodule

@@ hdl/chained_block_allocator_core.sv @@
// A step inside a block needs no link table access; a search or chain walk makes one
// link table access per cycle and visits at most NUM_BLOCKS entries, and a write at a
// block end whose chain ends there searches for and then appends a new block.
// A new request is accepted only once the previous response has been loaded.
// Reset (synchronous, active high) starts a clearing pass over all NUM_BLOCKS entries that
// marks every block free; req_stall stays high until it has finished.
module chained_block_allocator_core #(
   parameter int NUM_BLOCKS  = 256,
   parameter int BLOCK_WORDS = 128,
   parameter int BASE_WORDS  = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cba_pkg::COMMAND_W-1:0]   req_command,
   input  logic [cba_pkg::WORD_ADDR_W-1:0] req_word_address,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cba_pkg::WORD_ADDR_W-1:0] rsp_result_address,
   output logic [cba_pkg::STATUS_W-1:0]    rsp_status,
   output logic [cba_pkg::COUNT_W-1:0]     rsp_block_count
);

   // The controller decides what happens each cycle; the datapath holds the
   // request, the link table memory and the response register. They talk
   // only through these two structs.
   cba_pkg::ctrl_cmd_type  ctrl_cmd;
   cba_pkg::dp_status_type dp_status;

   // Controller: clearing pass, decode wait, search for the lowest free block, chain walk
   // for free and length, link follow and append at a block end, and the response hand-off.
   cba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // Datapath: the request is captured on acceptance, its block number is
   // found by a reciprocal multiplication registered in prod_ff and then blk_ff, and
   // the link table is read at one address and written at one per cycle.
   // The response register lets a finished response wait while the next
   // request is accepted.
   cba_datapath #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_WORDS (BLOCK_WORDS),
      .BASE_WORDS  (BASE_WORDS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_command        (req_command),
      .req_word_address   (req_word_address),
      .cmd                (ctrl_cmd),
      .status             (dp_status),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .rsp_block_count    (rsp_block_count)
   );

`ifndef ASSERT_OFF
   // The clearing pass must hold requests off straight after reset.
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request accepted before the link table was cleared");

   // A response is loaded only when the response register can take it.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while still waiting");

   // Every failing response carries a zero address.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != cba_pkg::ST_OK)) |-> (rsp_result_address == '0))
      else $error("failing response with a non-zero address");

   // Blocks are only counted by a walk, which never reports no free block or outside.
   a_count_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_block_count != '0)) |->
         ((rsp_status == cba_pkg::ST_OK) || (rsp_status == cba_pkg::ST_BROKEN)))
      else $error("block count with an unexpected status");
`endif

endmodule

@@ bench/tb_chained_block_allocator_core.sv @@
// Self-checking bench for chained_block_allocator_core: directed and random requests.
// Keeps its own link table to predict each response and compares them field by field.
// Depends on cba_pkg and the chained_block_allocator_core RTL.
module tb_chained_block_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BLOCKS  = 256;
   localparam int BLOCK_WORDS = 128;
   localparam int BASE_WORDS  = 1024;
   localparam int COMMAND_W   = cba_pkg::COMMAND_W;
   localparam int WORD_ADDR_W = cba_pkg::WORD_ADDR_W;
   localparam int STATUS_W    = cba_pkg::STATUS_W;
   localparam int COUNT_W     = cba_pkg::COUNT_W;
   localparam int STORE_END   = BASE_WORDS + NUM_BLOCKS * BLOCK_WORDS;
   localparam int LAST_WORD   = BLOCK_WORDS - 1;
   localparam int NEXT_W      = $clog2(NUM_BLOCKS);
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 3_000_000;

   // One entry of the bench's copy of the link table.
   typedef struct packed {
      cba_pkg::link_kind_type kind;
      logic [NEXT_W-1:0]      next;
   } link_entry_type;

   typedef struct packed {
      logic [COMMAND_W-1:0]   command;
      logic [WORD_ADDR_W-1:0] word_address;
   } request_type;

   typedef struct packed {
      logic [WORD_ADDR_W-1:0] result_address;
      cba_pkg::status_type    status;
      logic [COUNT_W-1:0]     block_count;
   } response_type;

   // How the stimulus picks a block from the current state of the table.
   typedef enum int {
      PICK_USED,
      PICK_TAIL,
      PICK_HEAD
   } pick_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [COMMAND_W-1:0]   req_command = '0;
   logic [WORD_ADDR_W-1:0] req_word_address = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [WORD_ADDR_W-1:0] rsp_result_address;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_W-1:0]     rsp_block_count;

   link_entry_type link_shadow [NUM_BLOCKS];
   request_type    request_queue [$];
   response_type   pending_responses [$];

   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_token  = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int error_count = 0;
   int cycle_count = 0;

   chained_block_allocator_core #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_WORDS (BLOCK_WORDS),
      .BASE_WORDS  (BASE_WORDS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_word_address   (req_word_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .rsp_block_count    (rsp_block_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // First word address of a block, wrapped to the address width as the block does.
   function automatic logic [WORD_ADDR_W-1:0] start_of(int blk);
      return WORD_ADDR_W'(BASE_WORDS + blk * BLOCK_WORDS);
   endfunction

   // Marks the lowest free block as the end of a new chain. Returns NUM_BLOCKS when
   // the store is full.
   function automatic int claim_lowest_free();
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         if (link_shadow[b].kind == cba_pkg::LINK_FREE) begin
            link_shadow[b] = '{cba_pkg::LINK_END, '0};
            return b;
         end
      end
      return NUM_BLOCKS;
   endfunction

   // Runs one request against the shadow table and returns the response it must give.
   function automatic response_type apply_request(logic [COMMAND_W-1:0] cmd,
                                                  logic [WORD_ADDR_W-1:0] addr);
      response_type   r;
      int             a;
      int             blk;
      int             nb;
      int             cur;
      int             n;
      int             s;
      bit             done;
      link_entry_type l;
      r = '{'0, cba_pkg::ST_OK, '0};
      a = int'(addr);
      blk = (a - BASE_WORDS) / BLOCK_WORDS;
      case (cmd)
         cba_pkg::CMD_ALLOCATE: begin
            nb = claim_lowest_free();
            if (nb >= NUM_BLOCKS) r.status = cba_pkg::ST_NO_FREE;
            else r.result_address = start_of(nb);
         end
         cba_pkg::CMD_FREE, cba_pkg::CMD_LENGTH: begin
            if (a < BASE_WORDS || a >= STORE_END) begin
               r.status = cba_pkg::ST_OUTSIDE;
            end else begin
               // The walk ends well on an end-of-chain entry; a free entry, or running
               // out of steps, leaves the status at broken with the blocks seen so far.
               cur = blk;
               n = 0;
               done = 1'b0;
               r.status = cba_pkg::ST_BROKEN;
               for (s = 0; s < NUM_BLOCKS && !done; s++) begin
                  l = link_shadow[cur];
                  if (l.kind == cba_pkg::LINK_FREE) begin
                     done = 1'b1;
                  end else begin
                     if (cmd == cba_pkg::CMD_FREE) link_shadow[cur] = '{cba_pkg::LINK_FREE, '0};
                     n++;
                     if (l.kind == cba_pkg::LINK_END) begin
                        r.status = cba_pkg::ST_OK;
                        done = 1'b1;
                     end else begin
                        cur = int'(l.next);
                     end
                  end
               end
               r.block_count = COUNT_W'(n);
            end
         end
         cba_pkg::CMD_READ, cba_pkg::CMD_WRITE: begin
            if (a < BASE_WORDS || a >= STORE_END) begin
               r.status = cba_pkg::ST_OUTSIDE;
            end else if (((a - BASE_WORDS + 1) % BLOCK_WORDS) != 0) begin
               // Inside a block the address simply steps on.
               r.result_address = WORD_ADDR_W'(a + 1);
            end else begin
               l = link_shadow[blk];
               case (l.kind)
                  cba_pkg::LINK_END: begin
                     if (cmd == cba_pkg::CMD_READ) begin
                        r.status = cba_pkg::ST_BROKEN;
                     end else begin
                        nb = claim_lowest_free();
                        if (nb >= NUM_BLOCKS) begin
                           r.status = cba_pkg::ST_NO_FREE;
                        end else begin
                           link_shadow[blk] = '{cba_pkg::LINK_NEXT, NEXT_W'(nb)};
                           r.result_address = start_of(nb);
                        end
                     end
                  end
                  cba_pkg::LINK_NEXT: r.result_address = start_of(int'(l.next));
                  default: r.status = cba_pkg::ST_BROKEN;
               endcase
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Picks a random block of the wanted sort, or -1 when there is none.
   function automatic int pick_block(pick_mode_type mode);
      int cand [$];
      bit pointed [NUM_BLOCKS];
      bit take;
      foreach (pointed[b]) pointed[b] = 1'b0;
      foreach (link_shadow[b]) begin
         if (link_shadow[b].kind == cba_pkg::LINK_NEXT) pointed[link_shadow[b].next] = 1'b1;
      end
      foreach (link_shadow[b]) begin
         case (mode)
            PICK_TAIL: take = (link_shadow[b].kind == cba_pkg::LINK_END);
            PICK_HEAD: take = (link_shadow[b].kind != cba_pkg::LINK_FREE) && !pointed[b];
            default:   take = (link_shadow[b].kind != cba_pkg::LINK_FREE);
         endcase
         if (take) cand.push_back(b);
      end
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(cand.size() - 1)];
   endfunction

   // Driver. The request on the ports is predicted at the edge that accepts it, and a
   // new one is only put up once the old one has gone, so a stalled payload holds still.
   always @(posedge clock) begin
      request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_responses.push_back(apply_request(req_command, req_word_address));
         end
         if (!req_valid || !req_stall) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = request_queue.pop_front();
               req_valid        <= 1'b1;
               req_command      <= nxt.command;
               req_word_address <= nxt.word_address;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and receiver. Each accepted response is checked against the oldest
   // prediction. The stall is random, except during a hold-off, which this process
   // counts down itself once the stimulus asks for one by bumping hold_token.
   always @(posedge clock) begin
      response_type exp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               $error("response with no request outstanding: result_address %0d",
                      rsp_result_address);
               error_count++;
            end else begin
               exp = pending_responses.pop_front();
               if (rsp_result_address !== exp.result_address) begin
                  $error("result_address expected %0d actual %0d",
                         exp.result_address, rsp_result_address);
                  error_count++;
               end
               if (rsp_status !== exp.status) begin
                  $error("status expected %0d actual %0d", exp.status, rsp_status);
                  error_count++;
               end
               if (rsp_block_count !== exp.block_count) begin
                  $error("block_count expected %0d actual %0d",
                         exp.block_count, rsp_block_count);
                  error_count++;
               end
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Queues a request. A tight request waits until everything before it has been
   // accepted, so that it is chosen from an exact picture of the link table.
   task automatic push_request(logic [COMMAND_W-1:0] cmd, logic [WORD_ADDR_W-1:0] addr,
                               bit tight);
      while (tight ? (request_queue.size() != 0 || req_valid) : (request_queue.size() >= 2))
         @(negedge clock);
      request_queue.push_back('{cmd, addr});
   endtask

   task automatic wait_drained();
      while (request_queue.size() != 0 || req_valid || pending_responses.size() != 0)
         @(negedge clock);
   endtask

   // One stretch of random requests. Most are well formed: they aim at chain heads,
   // tails and block ends taken from the current table. A few are pure noise.
   task automatic run_phase(int count, int idle, int stall, int wa, int wf, int wr,
                            int ww, bit tight, int hold_at);
      int                     r;
      int                     blk;
      int                     off;
      pick_mode_type          mode;
      logic [COMMAND_W-1:0]   cmd;
      logic [WORD_ADDR_W-1:0] addr;
      idle_pct  = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) hold_token++;
         r = int'($urandom_range(99));
         if ($urandom_range(99) < 5) begin
            cmd  = COMMAND_W'($urandom_range(2**COMMAND_W - 1));
            addr = WORD_ADDR_W'($urandom_range(2**WORD_ADDR_W - 1));
         end else begin
            if (r < wa) cmd = cba_pkg::CMD_ALLOCATE;
            else if (r < wa + wf) cmd = cba_pkg::CMD_FREE;
            else if (r < wa + wf + wr) cmd = cba_pkg::CMD_READ;
            else if (r < wa + wf + wr + ww) cmd = cba_pkg::CMD_WRITE;
            else cmd = cba_pkg::CMD_LENGTH;
            if (cmd == cba_pkg::CMD_ALLOCATE) begin
               addr = WORD_ADDR_W'($urandom_range(2**WORD_ADDR_W - 1));
            end else if ($urandom_range(99) < 4) begin
               addr = WORD_ADDR_W'($urandom_range(1) ? $urandom_range(BASE_WORDS - 1)
                                   : $urandom_range(2**WORD_ADDR_W - 1, STORE_END));
            end else begin
               if (cmd == cba_pkg::CMD_FREE || cmd == cba_pkg::CMD_LENGTH)
                  mode = ($urandom_range(99) < 85) ? PICK_HEAD : PICK_USED;
               else if (cmd == cba_pkg::CMD_WRITE && $urandom_range(99) < 70)
                  mode = PICK_TAIL;
               else
                  mode = PICK_USED;
               blk = pick_block(mode);
               if (blk < 0 || $urandom_range(9) == 0)
                  blk = int'($urandom_range(NUM_BLOCKS - 1));
               // Reads and writes mostly sit on the last word, where the link is used.
               if ((cmd == cba_pkg::CMD_READ || cmd == cba_pkg::CMD_WRITE)
                   && $urandom_range(99) < 60)
                  off = LAST_WORD;
               else
                  off = int'($urandom_range(LAST_WORD));
               addr = start_of(blk) + WORD_ADDR_W'(off);
            end
         end
         push_request(cmd, addr, tight);
      end
   endtask

   initial begin
      int blk;
      foreach (link_shadow[b]) link_shadow[b] = '{cba_pkg::LINK_FREE, '0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. The store starts all free, so every walk and link lookup on it
      // is broken, while a step inside a block still works without looking at links.
      idle_pct  = 14;
      stall_pct = 14;
      push_request(cba_pkg::CMD_LENGTH, start_of(0), 1'b0);
      push_request(cba_pkg::CMD_FREE, start_of(0) + WORD_ADDR_W'(5), 1'b0);
      push_request(cba_pkg::CMD_READ, start_of(0) + WORD_ADDR_W'(LAST_WORD), 1'b0);
      push_request(cba_pkg::CMD_WRITE, start_of(0) + WORD_ADDR_W'(LAST_WORD), 1'b0);
      push_request(cba_pkg::CMD_READ, start_of(0), 1'b0);
      // Allocation ignores the address; blocks 0 and 1 are handed out in turn.
      push_request(cba_pkg::CMD_ALLOCATE, '1, 1'b0);
      push_request(cba_pkg::CMD_ALLOCATE, '0, 1'b0);
      // Reading past the end of a chain is broken; writing there appends block 2.
      push_request(cba_pkg::CMD_READ, start_of(0) + WORD_ADDR_W'(LAST_WORD), 1'b0);
      push_request(cba_pkg::CMD_WRITE, start_of(0) + WORD_ADDR_W'(LAST_WORD), 1'b0);
      push_request(cba_pkg::CMD_READ, start_of(0) + WORD_ADDR_W'(LAST_WORD), 1'b0);
      push_request(cba_pkg::CMD_WRITE, start_of(0) + WORD_ADDR_W'(LAST_WORD), 1'b0);
      push_request(cba_pkg::CMD_LENGTH, start_of(0) + WORD_ADDR_W'(77), 1'b0);
      push_request(cba_pkg::CMD_FREE, start_of(0), 1'b0);
      push_request(cba_pkg::CMD_LENGTH, start_of(0), 1'b0);
      // Addresses just outside and just inside the store, and the ends of the address range.
      push_request(cba_pkg::CMD_READ, WORD_ADDR_W'(BASE_WORDS - 1), 1'b0);
      push_request(cba_pkg::CMD_WRITE, WORD_ADDR_W'(STORE_END), 1'b0);
      push_request(cba_pkg::CMD_FREE, '0, 1'b0);
      push_request(cba_pkg::CMD_LENGTH, '1, 1'b0);
      push_request(cba_pkg::CMD_READ, WORD_ADDR_W'(STORE_END - 1), 1'b0);
      push_request(cba_pkg::CMD_WRITE, WORD_ADDR_W'(STORE_END - 2), 1'b0);
      // Command codes beyond the defined ones must do nothing.
      for (int c = int'(cba_pkg::CMD_LENGTH) + 1; c < 2**COMMAND_W; c++)
         push_request(COMMAND_W'(c), c[0] ? 16'hAAAA : 16'h5555, 1'b0);

      // Random part: a general mix, then a phase that fills the store (with a long
      // hold-off on the response side), churn while full, and a draining phase.
      run_phase(300, 0, 0, 30, 8, 25, 27, 1'b0, -1);
      run_phase(350, 56, 0, 45, 2, 15, 30, 1'b0, 100);
      run_phase(300, 0, 56, 25, 15, 25, 25, 1'b0, -1);
      run_phase(250, 14, 14, 5, 40, 20, 10, 1'b0, -1);

      // Empty the store chain by chain, then grow a single chain across all of it so
      // that the longest walks and the full count are reached.
      wait_drained();
      idle_pct  = 0;
      stall_pct = 0;
      blk = pick_block(PICK_HEAD);
      while (blk >= 0) begin
         push_request(cba_pkg::CMD_FREE, start_of(blk), 1'b1);
         wait_drained();
         blk = pick_block(PICK_HEAD);
      end
      push_request(cba_pkg::CMD_ALLOCATE, '0, 1'b1);
      run_phase(400, 0, 0, 0, 0, 5, 85, 1'b1, -1);
      run_phase(350, 14, 14, 25, 12, 25, 25, 1'b0, -1);

      // Allow for a last walk to finish, so that a stray response would still be seen.
      wait_drained();
      repeat (NUM_BLOCKS + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("chained_block_allocator_core verification clean");
      end else begin
         $display("chained_block_allocator_core verification failed");
      end
      $finish;
   end

   // Watchdog on the cycle count, far beyond the slowest correct run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("chained_block_allocator_core verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/cba_pkg.sv
hdl/cba_ctrl.sv
hdl/cba_datapath.sv
hdl/chained_block_allocator_core.sv
bench/tb_chained_block_allocator_core.sv
